### src/byte_quantizer_with_histogram_defines.svh
// ----------------------------------------------------------------------------
// Byte quantizer assertion macros
// Immediate-style wrappers for concurrent checks; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BYTE_QUANTIZER_WITH_HISTOGRAM_DEFINES_SVH
`define BYTE_QUANTIZER_WITH_HISTOGRAM_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BQH_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bqh assertion failed");
// next-cycle implication
`define BQH_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bqh assertion failed");
`else
`define BQH_ASSERT_IMP(label, ck, rn, ante, cons)
`define BQH_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

### src/bqh_pkg.sv
// ----------------------------------------------------------------------------
// Byte quantizer package
// Item kinds, register indexes, code constants and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bqh_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int DIV_STEPS       = 8;
    localparam int DIV_CNT_WIDTH   = $clog2(DIV_STEPS);

    // item kinds
    localparam logic [1:0] KIND_QUANTIZE = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_BOUND  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_BOUND = 2'd1;

    localparam logic [7:0] CODE_LOW     = 8'd0;
    localparam logic [7:0] CODE_HIGH    = 8'd255;
    localparam logic [7:0] CODE_FLAT    = 8'd1;
    localparam logic [7:0] LINEAR_STEPS = 8'd253;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_MULTIPLY,
        S_DIVIDE,
        S_READ,
        S_UPDATE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic classify;
        logic multiply;
        logic div_step;
        logic mem_read;
        logic mem_update;
        logic clear_hist;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] in_kind;
        logic [1:0] item_kind;
        logic       direct;
        logic       div_last;
        logic       out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

### src/bqh_ctrl.sv
// ----------------------------------------------------------------------------
// Byte quantizer controller
// Sequences classify, multiply, divide and histogram access for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module bqh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bqh_pkg::ctrl_status_t status,
    output bqh_pkg::ctrl_cmd_t         cmd
);
    import bqh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (status.in_kind)
                        KIND_QUANTIZE: state_next = S_CLASSIFY;
                        KIND_READ:     state_next = S_READ;
                        KIND_CLEAR:
                        begin
                            cmd.clear_hist = 1'b1;
                            state_next     = S_RESULT;
                        end
                        default:       state_next = S_RESULT;
                    endcase
                end
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = S_MULTIPLY;
            end
            S_MULTIPLY:
            begin
                cmd.multiply = 1'b1;
                // skip the divider when the code is already known
                state_next   = status.direct ? S_READ : S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = (status.item_kind == KIND_QUANTIZE) ? S_UPDATE : S_RESULT;
            end
            S_UPDATE:
            begin
                cmd.mem_update = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/bqh_datapath.sv
// ----------------------------------------------------------------------------
// Byte quantizer datapath
// Range registers, classifier, multiplier, radix-2 divider, histogram memory
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bqh_datapath #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    input  wire logic [bqh_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [31:0]                           cfg_data,
    input  wire logic [1:0]                            kind,
    input  wire logic signed [31:0]                    sample,
    input  wire logic [7:0]                            bin_index,
    input  wire logic                                  last_of_volume,
    input  wire logic                                  out_ready,
    input  wire bqh_pkg::ctrl_cmd_t                    cmd,
    output bqh_pkg::ctrl_status_t                      status,
    output logic                                       out_valid,
    output logic [7:0]                                 code,
    output logic [31:0]                                bin_count,
    output logic                                       volume_end
);
    import bqh_pkg::*;

    localparam logic [31:0] LOW_RESET =
        32'(((64'd1002 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [31:0] HIGH_RESET =
        32'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam int NUM_BINS = 256;

    // configuration
    logic signed [31:0] low_bound_reg;
    logic signed [31:0] high_bound_reg;

    // item
    logic [1:0]         kind_reg;
    logic signed [31:0] sample_reg;
    logic [7:0]         bin_reg;
    logic               last_reg;

    // classifier
    logic [31:0]        off_reg;
    logic [31:0]        span_reg;
    logic               direct_reg;
    logic [7:0]         code_reg;
    logic [32:0]        off_full;
    logic [32:0]        span_full;
    logic               below;
    logic               above;
    logic               flat;

    // multiplier and divider
    logic [39:0]              product;
    logic [31:0]              rem_reg;
    logic [7:0]               quo_reg;
    logic [DIV_CNT_WIDTH-1:0] div_cnt_reg;
    logic [32:0]              trial;
    logic                     trial_ge;
    logic [32:0]              trial_diff;
    logic [7:0]               quo_next;

    // histogram
    logic [COUNT_WIDTH-1:0] hist_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    bin_valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [7:0]             mem_addr;
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH+31:0] count_ext;

    // result
    logic        out_valid_reg;
    logic [7:0]  out_code_reg;
    logic [31:0] out_count_reg;
    logic        out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg  <= LOW_RESET;
            high_bound_reg <= HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_BOUND:  low_bound_reg  <= cfg_data;
                REG_HIGH_BOUND: high_bound_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg   <= kind;
            sample_reg <= sample;
            bin_reg    <= bin_index;
            last_reg   <= last_of_volume;
        end
    end

    assign off_full  = {sample_reg[31], sample_reg} - {low_bound_reg[31], low_bound_reg};
    assign span_full = {high_bound_reg[31], high_bound_reg} - {low_bound_reg[31], low_bound_reg};
    assign below     = sample_reg < low_bound_reg;
    assign above     = sample_reg > high_bound_reg;
    assign flat      = high_bound_reg == low_bound_reg;

    assign product = {8'd0, off_reg} * {32'd0, LINEAR_STEPS};

    // shift one dividend bit into the partial remainder, subtract when it fits
    assign trial      = {rem_reg, quo_reg[7]};
    assign trial_ge   = trial >= {1'b0, span_reg};
    assign trial_diff = trial - {1'b0, span_reg};
    assign quo_next   = {quo_reg[6:0], trial_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            off_reg    <= off_full[31:0];
            span_reg   <= span_full[31:0];
            direct_reg <= below | above | flat;
            if (below)
            begin
                code_reg <= CODE_LOW;
            end
            else if (above)
            begin
                code_reg <= CODE_HIGH;
            end
            else
            begin
                code_reg <= CODE_FLAT;
            end
        end
        else if (cmd.div_step && (div_cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1)))
        begin
            code_reg <= quo_next + 8'd1;
        end

        if (cmd.multiply)
        begin
            // quotient fits in eight bits, so the top part is below the span
            rem_reg     <= product[39:8];
            quo_reg     <= product[7:0];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_diff[31:0] : trial[31:0];
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_WIDTH'(1);
        end
    end

    assign mem_addr = (kind_reg == KIND_QUANTIZE) ? code_reg : bin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_data_reg <= hist_mem[mem_addr];
        end
        if (cmd.mem_update)
        begin
            hist_mem[code_reg] <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mem_read)
            begin
                rd_valid_reg <= bin_valid_reg[mem_addr];
            end
            if (cmd.clear_hist)
            begin
                bin_valid_reg <= '0;
            end
            else if (cmd.mem_update)
            begin
                bin_valid_reg[code_reg] <= 1'b1;
            end
        end
    end

    assign count_cur  = rd_valid_reg ? rd_data_reg : '0;
    // hold at full scale
    assign count_next = (&count_cur) ? count_cur : count_cur + COUNT_WIDTH'(1);
    assign count_ext  = {32'd0, count_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_code_reg  <= (kind_reg == KIND_QUANTIZE) ? code_reg : CODE_LOW;
            out_count_reg <= (kind_reg == KIND_READ) ? count_ext[31:0] : 32'd0;
            out_end_reg   <= last_reg;
        end
    end

    assign status.in_kind   = kind;
    assign status.item_kind = kind_reg;
    assign status.direct    = direct_reg;
    assign status.div_last  = div_cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign code       = out_code_reg;
    assign bin_count  = out_count_reg;
    assign volume_end = out_end_reg;

endmodule

`default_nettype wire

### src/byte_quantizer_with_histogram.sv
// ----------------------------------------------------------------------------
// Byte quantizer with histogram
// An in-range sample is classified, multiplied, divided (8-step divider), then its bin
// is read and updated; a known code skips the divider, a bin read only reads, and a
// clear or unused kind goes straight to the result. One item in flight: the next item
// is taken the cycle after its result is loaded; a waiting result stalls the next one
// at its result. Reset sets low/high bounds to 1.002/1.1 and empties all bins at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_quantizer_with_histogram_defines.svh"

module byte_quantizer_with_histogram #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bqh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [31:0]                         cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          kind,
    input  wire logic signed [31:0]                  sample,
    input  wire logic [7:0]                          bin_index,
    input  wire logic                                last_of_volume,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [7:0]                               code,
    output logic [31:0]                              bin_count,
    output logic                                     volume_end
);
    import bqh_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    bqh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bqh_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .sample         (sample),
        .bin_index      (bin_index),
        .last_of_volume (last_of_volume),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .code           (code),
        .bin_count      (bin_count),
        .volume_end     (volume_end)
    );

    // one item at a time: busy right after an accept
    `BQH_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // never overwrite a result that is still waiting
    `BQH_ASSERT_IMP(a_no_result_overrun, clk, rst_n, cmd.load_out, !out_valid || out_ready)
    // a result carries a code or a count, never both
    `BQH_ASSERT_IMP(a_code_or_count, clk, rst_n, out_valid && (code != 8'd0), bin_count == 32'd0)

endmodule

`default_nettype wire
